>>> src/mesh_event_histogram_2d_macros.svh
// Assertion macros shared by the histogram modules.
`ifndef MESH_EVENT_HISTOGRAM_2D_MACROS_SVH
`define MESH_EVENT_HISTOGRAM_2D_MACROS_SVH

// Checks the consequence in the same cycle as the antecedent.
`define MEHIST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequence in the cycle after the antecedent.
`define MEHIST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mehist_pkg.sv
// Types and constants shared by the mesh histogram modules.
package mehist_pkg;

  localparam int POS_W      = 32;
  localparam int DVD_W      = POS_W - 1;
  localparam int QW         = 32;
  localparam int MESH_W     = 24;
  localparam int DIM_W      = 7;
  localparam int RD_IDX_W   = 6;
  localparam int OUT_CNT_W  = 16;
  localparam int CENTER_W   = 31;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = QW / 2;
  localparam int DIV_CNT_W  = 4;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MESH_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_X    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_Y    = 2'd2;

  localparam logic [MESH_W-1:0] MESH_RESET = 24'd256;
  localparam logic [DIM_W-1:0]  BINS_RESET = 7'd64;
  localparam logic [CENTER_W-1:0] CENTER_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RD_IDX_W-1:0] read_bin_x;
    logic [RD_IDX_W-1:0] read_bin_y;
  } in_item_t;

  typedef struct packed {
    logic                 in_range;
    logic [OUT_CNT_W-1:0] bin_count;
    logic [OUT_CNT_W-1:0] max_count;
    logic [CENTER_W-1:0]  center_x;
    logic [CENTER_W-1:0]  center_y;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLR_RST,
    ST_IDLE,
    ST_DECODE,
    ST_DIVX_GO,
    ST_DIVX_RUN,
    ST_DIVY_GO,
    ST_DIVY_RUN,
    ST_CHECK,
    ST_MEM_RD,
    ST_MEM_UPD,
    ST_CLR_CMD,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic item_load;
    logic rd_idx_load;
    logic div_start;
    logic div_sel;
    logic quo_store;
    logic mem_rd;
    logic mul_sel;
    logic mul_store;
    logic hit_set;
    logic upd;
    logic clr_step;
    logic max_clr;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             neg;
    logic             div_done;
    logic             hit;
    logic             clr_last;
    logic             out_free;
  } ctrl_stat_t;

endpackage

>>> src/mesh_event_histogram_2d.sv
// Two-dimensional mesh histogram of event positions with bin read-back and clear.
// An add transaction floors x and y by the mesh size on one shared radix-4 divider, x and then
// y (a start cycle, the iterations and a done cycle per axis), then reads and rewrites its bin
// in the counter memory; a bin outside the grid is left alone. A read transaction checks its bin
// against the grid and reads it if inside, and a negative add or an unused command goes straight
// to its result. The block takes one transaction at a time and holds in_stall high until its
// result has been handed to the output register. After reset, and for every clear transaction,
// one pass writes zero to all MAX_BINS_X * MAX_BINS_Y entries (4096 at the default size) of the
// counter memory, one entry per cycle; configuration writes are taken throughout.
module mesh_event_histogram_2d #(
  parameter int MAX_BINS_X = 64,
  parameter int MAX_BINS_Y = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mehist_pkg::in_item_t            in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mehist_pkg::out_item_t           out_data,
  input  logic                            cfg_we,
  input  logic [mehist_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mehist_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mehist_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t st;

  mehist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd_o    (cmd)
  );

  mehist_dp #(
    .MAX_BINS_X (MAX_BINS_X),
    .MAX_BINS_Y (MAX_BINS_Y),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

endmodule

>>> src/mehist_div.sv
// Restoring divider that retires two quotient bits per cycle.
module mehist_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mehist_pkg::DVD_W-1:0]  dividend,
  input  logic [mehist_pkg::MESH_W-1:0] divisor,
  output logic                        done,
  output logic [mehist_pkg::QW-1:0]     quotient
);
  import mehist_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [MESH_W-1:0]    rem_r;
  logic [MESH_W-1:0]    dvs_r;
  logic [QW-1:0]        dq_r;

  logic [MESH_W:0] t1;
  logic [MESH_W:0] r1;
  logic [MESH_W:0] t2;
  logic [MESH_W:0] r2;
  logic            ge1;
  logic            ge2;
  logic            last;

  always_comb begin
    t1   = {rem_r, dq_r[QW-1]};
    ge1  = (t1 >= {1'b0, dvs_r});
    r1   = ge1 ? (t1 - {1'b0, dvs_r}) : t1;
    t2   = {r1[MESH_W-1:0], dq_r[QW-2]};
    ge2  = (t2 >= {1'b0, dvs_r});
    r2   = ge2 ? (t2 - {1'b0, dvs_r}) : t2;
    last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dq_r  <= {1'b0, dividend};
    end else if (busy_r) begin
      rem_r <= r2[MESH_W-1:0];
      dq_r  <= {dq_r[QW-3:0], ge1, ge2};
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

>>> src/mehist_ctrl.sv
// Sequencer that steps each transaction through the histogram datapath.
`include "mesh_event_histogram_2d_macros.svh"

module mehist_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  mehist_pkg::ctrl_stat_t st,
  output mehist_pkg::ctrl_cmd_t  cmd_o
);
  import mehist_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR_RST: begin
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        case (st.cmd)
          CMD_ADD:   state_nxt = st.neg ? ST_DONE : ST_DIVX_GO;
          CMD_READ:  state_nxt = ST_CHECK;
          CMD_CLEAR: state_nxt = ST_CLR_CMD;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_DIVX_GO:  state_nxt = ST_DIVX_RUN;
      ST_DIVX_RUN: begin
        if (st.div_done) state_nxt = ST_DIVY_GO;
      end
      ST_DIVY_GO:  state_nxt = ST_DIVY_RUN;
      ST_DIVY_RUN: begin
        if (st.div_done) state_nxt = ST_CHECK;
      end
      ST_CHECK:    state_nxt = st.hit ? ST_MEM_RD : ST_DONE;
      ST_MEM_RD:   state_nxt = ST_MEM_UPD;
      ST_MEM_UPD:  state_nxt = ST_DONE;
      ST_CLR_CMD: begin
        if (st.clr_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_CLR_RST;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_r)
      ST_CLR_RST: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.max_clr  = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.item_load = accept;
      end
      ST_DECODE: begin
        cmd_o.rd_idx_load = (st.cmd == CMD_READ);
        cmd_o.max_clr     = (st.cmd == CMD_CLEAR);
      end
      ST_DIVX_GO: begin
        cmd_o.div_start = 1'b1;
      end
      ST_DIVX_RUN: begin
        cmd_o.quo_store = st.div_done;
      end
      ST_DIVY_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 1'b1;
      end
      ST_DIVY_RUN: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.quo_store = st.div_done;
      end
      ST_MEM_RD: begin
        cmd_o.mem_rd    = 1'b1;
        cmd_o.mul_store = 1'b1;
        cmd_o.hit_set   = 1'b1;
      end
      ST_MEM_UPD: begin
        cmd_o.upd       = 1'b1;
        cmd_o.mul_sel   = 1'b1;
        cmd_o.mul_store = 1'b1;
      end
      ST_CLR_CMD: begin
        cmd_o.clr_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.res_load = st.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `MEHIST_ASSERT_NEXT(a_load_decodes, accept, state_r == ST_DECODE, "accepted item not decoded")
  `MEHIST_ASSERT_SAME(a_res_free, cmd_o.res_load, st.out_free, "result loaded over a pending one")
  `MEHIST_ASSERT_NEXT(a_rst_clr_idle, (state_r == ST_CLR_RST) && st.clr_last, state_r == ST_IDLE, "clear pass after reset did not end in idle")
  `MEHIST_ASSERT_NEXT(a_div_x_to_y, (state_r == ST_DIVX_RUN) && st.div_done, state_r == ST_DIVY_GO, "y division not started")

endmodule

>>> src/mehist_dp.sv
// Datapath: configuration, divider, bin store, center multiplier and result register.
`include "mesh_event_histogram_2d_macros.svh"

module mehist_dp #(
  parameter int MAX_BINS_X = 64,
  parameter int MAX_BINS_Y = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mehist_pkg::in_item_t            in_data,
  input  mehist_pkg::ctrl_cmd_t           cmd,
  output mehist_pkg::ctrl_stat_t          st,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mehist_pkg::out_item_t           out_data,
  input  logic                            cfg_we,
  input  logic [mehist_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mehist_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mehist_pkg::*;

  localparam int XW    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
  localparam int YW    = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
  localparam int IW    = (XW > YW) ? XW : YW;
  localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = IW + 1 + MESH_W;

  logic [COUNT_BITS-1:0] mem [DEPTH];

  in_item_t              item_r;
  logic [QW-1:0]         ix_r;
  logic [QW-1:0]         iy_r;
  logic                  hit_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] max_r;
  logic [COUNT_BITS-1:0] rdata_r;
  logic [CENTER_W-1:0]   cx_r;
  logic [CENTER_W-1:0]   cy_r;
  logic [AW-1:0]         clr_addr_r;
  logic [MESH_W-1:0]     mesh_r;
  logic [DIM_W-1:0]      bins_x_r;
  logic [DIM_W-1:0]      bins_y_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [MESH_W-1:0]     mesh_eff;
  logic [QW-1:0]         nx;
  logic [QW-1:0]         ny;
  logic                  hit;
  logic [AW-1:0]         addr;
  logic                  is_add;
  logic [COUNT_BITS-1:0] inc;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [DVD_W-1:0]      div_dvd;
  logic                  div_done;
  logic [QW-1:0]         quotient;
  logic [IW-1:0]         idx_m;
  logic [PW-1:0]         prod;
  logic [63:0]           half64;
  logic [CENTER_W-1:0]   center;
  logic                  clr_last;
  logic                  out_free;
  logic [COUNT_BITS+OUT_CNT_W-1:0] cnt_ext;
  logic [COUNT_BITS+OUT_CNT_W-1:0] max_ext;

  assign mesh_eff = (mesh_r == '0) ? MESH_W'(1) : mesh_r;
  assign is_add   = (item_r.cmd == CMD_ADD);

  always_comb begin
    nx  = (QW'(bins_x_r) > QW'(MAX_BINS_X)) ? QW'(MAX_BINS_X) : QW'(bins_x_r);
    ny  = (QW'(bins_y_r) > QW'(MAX_BINS_Y)) ? QW'(MAX_BINS_Y) : QW'(bins_y_r);
    hit = (ix_r < nx) && (iy_r < ny);
  end

  assign addr = AW'(ix_r[XW-1:0]) + AW'(iy_r[YW-1:0]) * AW'(MAX_BINS_X);

  assign div_dvd = cmd.div_sel ? item_r.pos_y[DVD_W-1:0] : item_r.pos_x[DVD_W-1:0];

  mehist_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (mesh_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    idx_m  = cmd.mul_sel ? IW'(iy_r[YW-1:0]) : IW'(ix_r[XW-1:0]);
    prod   = PW'({idx_m, 1'b1}) * PW'(mesh_eff);
    half64 = 64'(prod[PW-1:1]);
    center = (half64 > 64'(CENTER_MAX)) ? CENTER_MAX : half64[CENTER_W-1:0];
  end

  assign inc     = (&rdata_r) ? rdata_r : rdata_r + COUNT_BITS'(1);
  assign wr_en   = cmd.clr_step || (cmd.upd && is_add);
  assign wr_addr = cmd.clr_step ? clr_addr_r : addr;
  assign wr_data = cmd.clr_step ? '0 : inc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign clr_last = (clr_addr_r == AW'(DEPTH - 1));
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_r      <= MESH_RESET;
      bins_x_r    <= BINS_RESET;
      bins_y_r    <= BINS_RESET;
      max_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MESH_SIZE: mesh_r   <= cfg_wdata[MESH_W-1:0];
          CFG_BINS_X:    bins_x_r <= cfg_wdata[DIM_W-1:0];
          CFG_BINS_Y:    bins_y_r <= cfg_wdata[DIM_W-1:0];
          default:       ;
        endcase
      end
      if (cmd.max_clr) begin
        max_r <= '0;
      end else if (cmd.upd && is_add && (inc > max_r)) begin
        max_r <= inc;
      end
      if (cmd.clr_step) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_data;
      hit_r  <= 1'b0;
    end else if (cmd.hit_set) begin
      hit_r <= 1'b1;
    end
    if (cmd.rd_idx_load) begin
      ix_r <= QW'(item_r.read_bin_x);
      iy_r <= QW'(item_r.read_bin_y);
    end else if (cmd.quo_store) begin
      if (cmd.div_sel) begin
        iy_r <= quotient;
      end else begin
        ix_r <= quotient;
      end
    end
    if (cmd.mul_store) begin
      if (cmd.mul_sel) begin
        cy_r <= center;
      end else begin
        cx_r <= center;
      end
    end
    if (cmd.upd) begin
      cnt_r <= is_add ? inc : rdata_r;
    end
  end

  assign cnt_ext = {{OUT_CNT_W{1'b0}}, cnt_r};
  assign max_ext = {{OUT_CNT_W{1'b0}}, max_r};

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r.in_range  <= hit_r;
      out_r.bin_count <= hit_r ? cnt_ext[OUT_CNT_W-1:0] : '0;
      out_r.max_count <= max_ext[OUT_CNT_W-1:0];
      out_r.center_x  <= hit_r ? cx_r : '0;
      out_r.center_y  <= hit_r ? cy_r : '0;
    end
  end

  always_comb begin
    st          = '0;
    st.cmd      = item_r.cmd;
    st.neg      = item_r.pos_x[POS_W-1] || item_r.pos_y[POS_W-1];
    st.div_done = div_done;
    st.hit      = hit;
    st.clr_last = clr_last;
    st.out_free = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MEHIST_ASSERT_NEXT(a_max_covers_cnt, cmd.upd && is_add, max_r >= cnt_r, "running maximum below updated count")
  `MEHIST_ASSERT_NEXT(a_res_shows, cmd.res_load, out_valid_r, "loaded result not presented")
  `MEHIST_ASSERT_NEXT(a_clr_wraps, cmd.clr_step && clr_last, clr_addr_r == '0, "clear address did not wrap")
  `MEHIST_ASSERT_SAME(a_hit_in_grid, cmd.hit_set, hit, "bin access outside the grid")

endmodule

>>> test/mesh_event_histogram_2d_tb.sv
// Self-checking testbench for mesh_event_histogram_2d: directed and random transactions.
module mesh_event_histogram_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mehist_pkg::*;

  localparam int unsigned GRID_X = 64;
  localparam int unsigned GRID_Y = 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_GAP = 50;
  localparam int PHASE_ITEMS = 216;
  localparam int HOLD_CYCLES = 600;

  class bin_tally;
    bit [OUT_CNT_W-1:0] tally [GRID_X*GRID_Y];
    bit [OUT_CNT_W-1:0] peak;
    int unsigned mesh;
    int unsigned cols;
    int unsigned rows;
    out_item_t awaited [$];
    int errors;

    function new();
      foreach (tally[i]) tally[i] = '0;
      peak = '0;
      mesh = MESH_RESET;
      cols = BINS_RESET;
      rows = BINS_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MESH_SIZE: mesh = data;
        CFG_BINS_X:    cols = data[DIM_W-1:0];
        CFG_BINS_Y:    rows = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_mesh();
      return (mesh == 0) ? 1 : mesh;
    endfunction

    function int unsigned grid_cols();
      return (cols > GRID_X) ? GRID_X : cols;
    endfunction

    function int unsigned grid_rows();
      return (rows > GRID_Y) ? GRID_Y : rows;
    endfunction

    function bit [CENTER_W-1:0] center(int unsigned idx);
      longint unsigned c;
      c = ((64'(idx) * 2 + 1) * 64'(eff_mesh())) >> 1;
      if (c > 64'(CENTER_MAX)) c = 64'(CENTER_MAX);
      return c[CENTER_W-1:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      bit neg;
      int unsigned m, nx, ny, ix, iy, k;
      r = '0;
      m = eff_mesh();
      nx = grid_cols();
      ny = grid_rows();
      case (it.cmd)
        CMD_ADD: begin
          neg = it.pos_x[POS_W-1] | it.pos_y[POS_W-1];
          ix = $unsigned(it.pos_x) / m;
          iy = $unsigned(it.pos_y) / m;
          if (!neg && ix < nx && iy < ny) begin
            k = ix + iy * GRID_X;
            if (tally[k] != '1) tally[k]++;
            if (tally[k] > peak) peak = tally[k];
            r.in_range = 1'b1;
            r.bin_count = tally[k];
            r.center_x = center(ix);
            r.center_y = center(iy);
          end
        end
        CMD_READ: begin
          ix = it.read_bin_x;
          iy = it.read_bin_y;
          if (ix < nx && iy < ny) begin
            r.in_range = 1'b1;
            r.bin_count = tally[ix + iy * GRID_X];
            r.center_x = center(ix);
            r.center_y = center(iy);
          end
        end
        CMD_CLEAR: begin
          foreach (tally[i]) tally[i] = '0;
          peak = '0;
        end
        default: ;
      endcase
      r.max_count = peak;
      awaited.push_back(r);
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        report("result transaction arrived with nothing expected");
        return;
      end
      want = awaited.pop_front();
      if (got.in_range !== want.in_range)
        report($sformatf("in_range %0b, expected %0b", got.in_range, want.in_range));
      if (got.bin_count !== want.bin_count)
        report($sformatf("bin_count %0d, expected %0d", got.bin_count, want.bin_count));
      if (got.max_count !== want.max_count)
        report($sformatf("max_count %0d, expected %0d", got.max_count, want.max_count));
      if (got.center_x !== want.center_x)
        report($sformatf("center_x %0d, expected %0d", got.center_x, want.center_x));
      if (got.center_y !== want.center_y)
        report($sformatf("center_y %0d, expected %0d", got.center_y, want.center_y));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bin_tally sb = new();
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;

  int unsigned phase_mesh [8] = '{1, 24'hFFFFFF, 0, 1000, 300, 77, 5, 256};
  int unsigned phase_cols [8] = '{64, 127, 8, 1, 0, 33, 64, 64};
  int unsigned phase_rows [8] = '{64, 1, 8, 64, 5, 17, 127, 64};

  mesh_event_histogram_2d u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("mesh_event_histogram_2d_tb NOT OK");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (rx_stall_pct > 0) && ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [31:0] px,
                                         logic [31:0] py, logic [5:0] rx, logic [5:0] ry);
    in_item_t it;
    it.cmd = cmd;
    it.pos_x = px;
    it.pos_y = py;
    it.read_bin_x = rx;
    it.read_bin_y = ry;
    return it;
  endfunction

  function automatic int unsigned pick_bin(int unsigned n);
    if (n == 0) return 0;
    if ($urandom_range(1)) return $urandom_range(((n > 4) ? 4 : n) - 1);
    return $urandom_range(n - 1);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned m, nx, ny, r;
    longint unsigned px, py;
    it = make_item(CMD_ADD, $urandom, $urandom, RD_IDX_W'($urandom), RD_IDX_W'($urandom));
    m = sb.eff_mesh();
    nx = sb.grid_cols();
    ny = sb.grid_rows();
    px = 64'(pick_bin(nx)) * m + $urandom_range(m - 1);
    py = 64'(pick_bin(ny)) * m + $urandom_range(m - 1);
    r = $urandom_range(99);
    if (r < 60) begin
      it.pos_x = px[31:0];
      it.pos_y = py[31:0];
    end else if (r < 68) begin
      if ($urandom_range(1)) begin
        px = 64'(nx + $urandom_range(3)) * m + $urandom_range(m - 1);
      end else begin
        py = 64'(ny + $urandom_range(3)) * m + $urandom_range(m - 1);
      end
      it.pos_x = px[31:0];
      it.pos_y = py[31:0];
    end else if (r < 75) begin
      it.pos_x = px[31:0];
      it.pos_y = py[31:0];
      case ($urandom_range(2))
        0: it.pos_x[POS_W-1] = 1'b1;
        1: it.pos_y[POS_W-1] = 1'b1;
        default: begin
          it.pos_x[POS_W-1] = 1'b1;
          it.pos_y[POS_W-1] = 1'b1;
        end
      endcase
    end else if (r < 82) begin
      it.cmd = CMD_ADD;
    end else if (r < 95) begin
      it.cmd = CMD_READ;
      if ($urandom_range(1)) begin
        it.read_bin_x = RD_IDX_W'(pick_bin(nx));
        it.read_bin_y = RD_IDX_W'(pick_bin(ny));
      end
    end else if (r < 98) begin
      it.cmd = CMD_UNUSED;
    end else if (r < 99) begin
      it.cmd = CMD_CLEAR;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    while ((tx_idle_pct > 0) && ($urandom_range(99) < tx_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(make_item(CMD_ADD, 32'd0, 32'd0, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'd0, 32'd0, 6'd63, 6'd63));
    send_item(make_item(CMD_ADD, 32'd16383, 32'd16383, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'd16384, 32'd0, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'd0, 32'd16384, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'hFFFF_FFFF, 32'd0, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'd0, 32'h8000_0000, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63));
    send_item(make_item(CMD_READ, 32'd0, 32'd0, 6'd0, 6'd0));
    send_item(make_item(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63));
    send_item(make_item(CMD_READ, 32'd0, 32'd0, 6'd10, 6'd20));
    send_item(make_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63));
    send_item(make_item(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 6'd63));
    send_item(make_item(CMD_READ, 32'd0, 32'd0, 6'd0, 6'd0));
    send_item(make_item(CMD_ADD, 32'd2688, 32'd768, 6'd0, 6'd0));
    send_item(make_item(CMD_READ, 32'd0, 32'd0, 6'd10, 6'd3));
    send_item(make_item(CMD_ADD, 32'd128, 32'd128, 6'd0, 6'd0));

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      cfg_write(CFG_MESH_SIZE, CFG_DATA_W'(phase_mesh[p]));
      cfg_write(CFG_BINS_X, CFG_DATA_W'(phase_cols[p]));
      cfg_write(CFG_BINS_Y, CFG_DATA_W'(phase_rows[p]));
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
        default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
      endcase
      if (p == 7) hold_left = HOLD_CYCLES;
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    wait_drained();
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("mesh_event_histogram_2d_tb OK");
    end else begin
      $display("mesh_event_histogram_2d_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/mehist_pkg.sv
src/mehist_div.sv
src/mehist_ctrl.sv
src/mehist_dp.sv
src/mesh_event_histogram_2d.sv
test/mesh_event_histogram_2d_tb.sv
